// File: design/cch_pkg.sv
// Package for the combination count hash table: request and result types,
// field widths, hash constants and the single hash step function.
// Depends on nothing; the core and the hash unit import it, the RAM does not.
package cch_pkg;

  localparam int KEY_W           = 32;
  localparam int NUM_KEY_FIELDS  = 8;
  localparam int INCR_W          = 32;
  localparam int ID_W            = 11;
  localparam int COUNT_W         = 64;
  localparam int SEED_W          = 64;
  localparam int LEN_CFG_W       = 4;
  localparam int DEF_MAX_KEY_LEN = 8;
  localparam int DEF_TABLE_DEPTH = 1024;

  localparam logic [KEY_W-1:0] HASH_GOLDEN = 32'h9e3779b9;
  localparam int               HASH_SHL    = 6;
  localparam int               HASH_SHR    = 2;

  // One request: up to eight key components and the count increment.
  typedef struct packed {
    logic signed [KEY_W-1:0] key_0;
    logic signed [KEY_W-1:0] key_1;
    logic signed [KEY_W-1:0] key_2;
    logic signed [KEY_W-1:0] key_3;
    logic signed [KEY_W-1:0] key_4;
    logic signed [KEY_W-1:0] key_5;
    logic signed [KEY_W-1:0] key_6;
    logic signed [KEY_W-1:0] key_7;
    logic [INCR_W-1:0]       increment;
  } request_t;

  // One result: the entry id and the full flag.
  typedef struct packed {
    logic [ID_W-1:0] entry_id;
    logic            table_full;
  } result_t;

  // Status handed from the hash unit to the sequencer.
  typedef struct packed {
    logic              done;
    logic [SEED_W-1:0] seed;
  } hash_out_t;

  // One round of the seed mixing: seed ^= term + (seed << 6) + (seed >> 2).
  function automatic logic [SEED_W-1:0] hash_step(input logic [SEED_W-1:0] seed,
                                                  input logic [KEY_W-1:0]  comp);
    logic [KEY_W-1:0]  term32;
    logic [SEED_W-1:0] term;
    term32 = comp + HASH_GOLDEN;
    term   = {{(SEED_W-KEY_W){1'b0}}, term32};
    return seed ^ (term + (seed << HASH_SHL) + (seed >> HASH_SHR));
  endfunction

endpackage

// File: design/combination_count_hash_table_core.sv
// Top level of the combination count hash table: request capture, probe
// sequencer and count update. Depends on cch_pkg, cch_hash and cch_ram.
//
//   Channel   | Handshake           | Payload
//   ----------+---------------------+---------------------------------
//   request   | start high, busy low| request (keys, increment)
//   result    | done, one cycle     | result (entry_id, table_full)
//   config    | cfg_we              | cfg_data (key_length)
//
// A request with zero increment answers in the cycle after acceptance. Otherwise
// a request passes through the hash unit, which mixes one key component per
// cycle for the key length in use (after clamping), and then through one read
// and one check of the slot memory per probe slot; a full table probes all
// TABLE_DEPTH slots. After reset a clearing pass over all TABLE_DEPTH slots
// empties the slot memory while busy is high. Results cannot be held
// off by the receiver. TABLE_DEPTH must be a power of two.
module combination_count_hash_table_core #(
  parameter int MAX_KEY_LEN = cch_pkg::DEF_MAX_KEY_LEN,
  parameter int TABLE_DEPTH = cch_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  cch_pkg::request_t               request,
  output logic                            busy,
  output logic                            done,
  output cch_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [cch_pkg::LEN_CFG_W-1:0]   cfg_data
);

  import cch_pkg::*;

  localparam int LEN_W     = $clog2(MAX_KEY_LEN+1);
  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int KEYS_W    = KEY_W * MAX_KEY_LEN;
  localparam int COUNT_LSB = KEYS_W;
  localparam int ID_LSB    = COUNT_LSB + COUNT_W;
  localparam int VALID_BIT = ID_LSB + ID_W;
  localparam int ROW_W     = VALID_BIT + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_t;

  state_t                                state;
  logic [LEN_CFG_W-1:0]                  key_length;
  logic [LEN_W-1:0]                      len_used;
  logic [LEN_W-1:0]                      len_reg;
  logic [MAX_KEY_LEN-1:0][KEY_W-1:0]     key_reg;
  logic [INCR_W-1:0]                     incr_reg;
  logic [IDX_W-1:0]                      slot;
  logic [IDX_W-1:0]                      probe_cnt;
  logic [ID_W-1:0]                       last_id;
  logic [ID_W-1:0]                       new_id;
  logic [NUM_KEY_FIELDS-1:0][KEY_W-1:0]  keys_in;
  logic                                  accept;
  logic                                  hash_start;
  logic                                  done_next;
  hash_out_t                             hash_out;

  logic                                  ram_we;
  logic [ROW_W-1:0]                      ram_wdata;
  logic [ROW_W-1:0]                      row;
  logic                                  row_valid;
  logic [ID_W-1:0]                       row_id;
  logic [COUNT_W-1:0]                    row_count;
  logic [KEYS_W-1:0]                     row_keys;
  logic                                  key_match;
  logic [COUNT_W:0]                      sum;
  logic [COUNT_W-1:0]                    sat_count;

  // Request handshake.
  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign hash_start = accept && (request.increment != '0);
  assign new_id     = last_id + ID_W'(1);

  // Key fields as an indexable vector.
  assign keys_in = {request.key_7, request.key_6, request.key_5, request.key_4,
                    request.key_3, request.key_2, request.key_1, request.key_0};

  // Effective key length: zero counts as one, larger values clamp to the maximum.
  always_comb begin
    if (key_length == '0) begin
      len_used = LEN_W'(1);
    end else if (key_length > LEN_CFG_W'(MAX_KEY_LEN)) begin
      len_used = LEN_W'(MAX_KEY_LEN);
    end else begin
      len_used = LEN_W'(key_length);
    end
  end

  cch_hash #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .len   (len_reg),
    .key   (key_reg),
    .status(hash_out)
  );

  // Slot memory row: valid flag, id, count and all key components.
  cch_ram #(
    .WIDTH(ROW_W),
    .DEPTH(TABLE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(row)
  );

  assign row_valid = row[VALID_BIT];
  assign row_id    = row[ID_LSB +: ID_W];
  assign row_count = row[COUNT_LSB +: COUNT_W];
  assign row_keys  = row[KEYS_W-1:0];

  // Compare the components in use against the stored key.
  always_comb begin
    key_match = 1'b1;
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      if ((LEN_W'(i) < len_reg) && (row_keys[i*KEY_W +: KEY_W] != key_reg[i])) begin
        key_match = 1'b0;
      end
    end
  end

  // Saturating count update.
  assign sum       = {1'b0, row_count} + {{(COUNT_W+1-INCR_W){1'b0}}, incr_reg};
  assign sat_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

  // Result strobe: a zero increment at once, otherwise when the probe ends.
  assign done_next = (accept && (request.increment == '0)) ||
                     ((state == S_CHECK) &&
                      (!row_valid || key_match || (probe_cnt == IDX_W'(TABLE_DEPTH-1))));

  // Memory write: clearing pass, insertion of a new key, or count update.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_CHECK) begin
      if (!row_valid) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, new_id, {(COUNT_W-INCR_W){1'b0}}, incr_reg, key_reg};
      end else if (key_match) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, row_id, sat_count, row_keys};
      end
    end
  end

  // Sequencer with the request capture and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      slot       <= '0;
      probe_cnt  <= '0;
      last_id    <= '0;
      key_length <= LEN_CFG_W'(1);
      done       <= 1'b0;
      result     <= '0;
    end else begin
      done <= done_next;
      if (cfg_we) begin
        key_length <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          slot <= slot + IDX_W'(1);
          if (slot == IDX_W'(TABLE_DEPTH-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
              key_reg[i] <= keys_in[i];
            end
            incr_reg  <= request.increment;
            len_reg   <= len_used;
            probe_cnt <= '0;
            if (request.increment == '0) begin
              result <= '0;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_out.done) begin
            slot  <= hash_out.seed[IDX_W-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!row_valid) begin
            last_id           <= new_id;
            result.entry_id   <= new_id;
            result.table_full <= 1'b0;
            state             <= S_IDLE;
          end else if (key_match) begin
            result.entry_id   <= row_id;
            result.table_full <= 1'b0;
            state             <= S_IDLE;
          end else if (probe_cnt == IDX_W'(TABLE_DEPTH-1)) begin
            result.entry_id   <= '0;
            result.table_full <= 1'b1;
            state             <= S_IDLE;
          end else begin
            slot      <= slot + IDX_W'(1);
            probe_cnt <= probe_cnt + IDX_W'(1);
            state     <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A full table never reports an id.
  a_full_no_id: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> (result.entry_id == '0))
    else $error("table_full reported together with a nonzero id");

  // A zero increment is answered in the next cycle with id 0.
  a_zero_incr: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.increment == '0)) |=>
      (done && (result.entry_id == '0) && !result.table_full))
    else $error("zero increment not answered at once");

  // Every result leaves the sequencer ready for the next request.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the sequencer is still busy");

  // The hash unit only finishes while the sequencer waits for it.
  a_hash_state: assert property (@(posedge clk) disable iff (rst)
    hash_out.done |-> (state == S_HASH))
    else $error("hash finished outside the hash wait state");
`endif

endmodule

// File: design/cch_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cch_hash.sv
// Iterative key hash: one shared mixing step applied to one key component
// per cycle. Depends on cch_pkg.
module cch_hash #(
  parameter int MAX_KEY_LEN = cch_pkg::DEF_MAX_KEY_LEN
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [$clog2(MAX_KEY_LEN+1)-1:0]          len,
  input  logic [MAX_KEY_LEN-1:0][cch_pkg::KEY_W-1:0] key,
  output cch_pkg::hash_out_t                        status
);

  import cch_pkg::*;

  localparam int LEN_W  = $clog2(MAX_KEY_LEN+1);
  localparam int KIDX_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  logic              run;
  logic [KIDX_W-1:0] cnt;
  logic [SEED_W-1:0] seed;
  logic              done;
  logic              last;

  assign last          = (LEN_W'(cnt) == (len - LEN_W'(1)));
  assign status.done   = done;
  assign status.seed   = seed;

  // Sequencer for the component loop; the seed register holds the running hash.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !start && last;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        seed <= '0;
      end else if (run) begin
        seed <= hash_step(seed, key[cnt]);
        if (last) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt + KIDX_W'(1);
        end
      end
    end
  end

endmodule
